### hdl/lrpw_pkg.sv
// Shared types, constants and register codes of the line rasterizer pixel writer.
package lrpw_pkg;

    localparam int BYTES_PER_PIXEL_DEF = 3;
    localparam int COORD_BITS_DEF      = 16;
    localparam int ADDR_BITS           = 28;

    localparam logic [13:0] IMAGE_WIDTH_RESET   = 14'd640;
    localparam logic [13:0] IMAGE_HEIGHT_RESET  = 14'd480;
    localparam logic [15:0] BYTES_PER_ROW_RESET = 16'd1920;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_ROW = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
    } lrpw_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] pixel_address;
        logic                 visible;
        logic [7:0]           red_out;
        logic [7:0]           green_out;
        logic [7:0]           blue_out;
        logic                 last_pixel;
    } lrpw_out_t;

    typedef struct packed {
        logic [13:0] image_width;
        logic [13:0] image_height;
        logic [15:0] bytes_per_row;
    } lrpw_cfg_t;

endpackage

### hdl/lrpw_front.sv
// Front part: accepts items, holds the line state and steps the error term.
module lrpw_front
    import lrpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  lrpw_in_t                  item,
    output logic                      q_push,
    output logic [2*COORD_BITS+24:0]  q_data
);

    localparam int CW = COORD_BITS;
    localparam int SW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic signed [CW-1:0] cursor_x_reg, cursor_x_next;
    logic signed [CW-1:0] cursor_y_reg, cursor_y_next;
    logic signed [CW-1:0] target_x_reg, target_x_next;
    logic signed [CW-1:0] target_y_reg, target_y_next;
    logic [SW-1:0]        span_x_reg, span_x_next;
    logic [SW-1:0]        span_y_reg, span_y_next;
    logic                 step_right_reg, step_right_next;
    logic                 step_up_reg, step_up_next;
    logic signed [EW-1:0] error_term_reg, error_term_next;
    logic [23:0]          line_colour_reg, line_colour_next;
    logic                 active_reg, active_next;
    logic                 endpoint_sent_reg, endpoint_sent_next;

    logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
    logic signed [SW-1:0] diff_x, diff_y;
    logic signed [EW-1:0] e2, span_x_s, span_y_s, err_work;
    logic signed [CW-1:0] step_x, step_y;
    logic signed [CW-1:0] ent_x, ent_y;
    logic                 ent_last;

    assign in_sx = CW'(item.start_x);
    assign in_sy = CW'(item.start_y);
    assign in_ex = CW'(item.end_x);
    assign in_ey = CW'(item.end_y);
    assign diff_x = SW'(in_ex) - SW'(in_sx);
    assign diff_y = SW'(in_ey) - SW'(in_sy);

    assign span_x_s = $signed({2'b00, span_x_reg});
    assign span_y_s = $signed({2'b00, span_y_reg});
    assign e2 = error_term_reg <<< 1;
    assign step_x = step_right_reg ? CW'(1) : -CW'(1);
    assign step_y = step_up_reg ? CW'(1) : -CW'(1);

    always_comb
    begin
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        target_x_next      = target_x_reg;
        target_y_next      = target_y_reg;
        span_x_next        = span_x_reg;
        span_y_next        = span_y_reg;
        step_right_next    = step_right_reg;
        step_up_next       = step_up_reg;
        error_term_next    = error_term_reg;
        line_colour_next   = line_colour_reg;
        active_next        = active_reg;
        endpoint_sent_next = endpoint_sent_reg;
        err_work           = error_term_reg;
        q_push             = 1'b0;
        ent_x              = target_x_reg;
        ent_y              = target_y_reg;
        ent_last           = 1'b0;
        if (take)
        begin
            if (item.kind == KIND_START)
            begin
                cursor_x_next      = in_sx;
                cursor_y_next      = in_sy;
                target_x_next      = in_ex;
                target_y_next      = in_ey;
                span_x_next        = diff_x[SW-1] ? SW'(-diff_x) : SW'(diff_x);
                span_y_next        = diff_y[SW-1] ? SW'(-diff_y) : SW'(diff_y);
                step_right_next    = in_sx < in_ex;
                step_up_next       = in_sy < in_ey;
                error_term_next    = EW'(signed'({1'b0, span_x_next}))
                                   - EW'(signed'({1'b0, span_y_next}));
                line_colour_next   = {item.red_in, item.green_in, item.blue_in};
                active_next        = 1'b1;
                endpoint_sent_next = 1'b0;
            end
            else if (active_reg && !endpoint_sent_reg)
            begin
                q_push             = 1'b1;
                ent_last           = (cursor_x_reg == target_x_reg) &&
                                     (cursor_y_reg == target_y_reg);
                endpoint_sent_next = 1'b1;
                active_next        = !ent_last;
            end
            else if (active_reg)
            begin
                q_push = 1'b1;
                ent_x  = cursor_x_reg;
                ent_y  = cursor_y_reg;
                if (e2 > -span_y_s)
                begin
                    err_work      = err_work - span_y_s;
                    cursor_x_next = cursor_x_reg + step_x;
                end
                if (e2 < span_x_s)
                begin
                    err_work      = err_work + span_x_s;
                    cursor_y_next = cursor_y_reg + step_y;
                end
                error_term_next = err_work;
                ent_last        = (cursor_x_next == target_x_reg) &&
                                  (cursor_y_next == target_y_reg);
                active_next     = !ent_last;
            end
        end
    end

    assign q_data = {ent_x, ent_y, ent_last, line_colour_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            target_x_reg      <= '0;
            target_y_reg      <= '0;
            span_x_reg        <= '0;
            span_y_reg        <= '0;
            step_right_reg    <= 1'b0;
            step_up_reg       <= 1'b0;
            error_term_reg    <= '0;
            line_colour_reg   <= '0;
            active_reg        <= 1'b0;
            endpoint_sent_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            target_x_reg      <= target_x_next;
            target_y_reg      <= target_y_next;
            span_x_reg        <= span_x_next;
            span_y_reg        <= span_y_next;
            step_right_reg    <= step_right_next;
            step_up_reg       <= step_up_next;
            error_term_reg    <= error_term_next;
            line_colour_reg   <= line_colour_next;
            active_reg        <= active_next;
            endpoint_sent_reg <= endpoint_sent_next;
        end
    end

endmodule

### hdl/lrpw_queue.sv
// Short pixel queue between the front and back parts.
module lrpw_queue
    import lrpw_pkg::*;
#(
    parameter int WIDTH = 2 * COORD_BITS_DEF + 25,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign full    = count_reg == NW'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/lrpw_back.sv
// Back part: maps pixels to the screen, clips them and forms write addresses.
module lrpw_back
    import lrpw_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lrpw_cfg_t                 cfg,
    input  logic                      q_empty,
    input  logic [2*COORD_BITS+24:0]  q_data,
    output logic                      q_pop,
    output lrpw_out_t                 result,
    output logic                      empty,
    input  logic                      pop
);

    localparam int CW = COORD_BITS;
    localparam int PW = COORD_BITS + 16;

    logic signed [CW-1:0] pix_x, pix_y;
    logic                 pix_last;
    logic [23:0]          pix_colour;
    logic signed [PW-1:0] col, row;
    logic                 vis;

    logic        s1_valid_reg;
    logic [13:0] s1_col_reg;
    logic [13:0] s1_row_reg;
    logic        s1_vis_reg;
    logic        s1_last_reg;
    logic [23:0] s1_colour_reg;

    logic      out_valid_reg;
    lrpw_out_t out_reg;

    logic        out_free, s1_adv;
    logic [29:0] row_bytes;
    logic [16:0] col_bytes;
    logic [ADDR_BITS-1:0] addr;

    assign {pix_x, pix_y, pix_last, pix_colour} = q_data;

    assign col = PW'($signed({1'b0, cfg.image_width[13:1]})) + PW'(pix_x);
    assign row = PW'($signed({1'b0, cfg.image_height[13:1]})) - PW'(pix_y);
    assign vis = !col[PW-1] && !row[PW-1] &&
                 (col < PW'($signed({1'b0, cfg.image_width}))) &&
                 (row < PW'($signed({1'b0, cfg.image_height})));

    assign out_free = !out_valid_reg || pop;
    assign s1_adv   = !s1_valid_reg || out_free;
    assign q_pop    = !q_empty && s1_adv;

    assign row_bytes = 30'(s1_row_reg) * 30'(cfg.bytes_per_row);
    assign col_bytes = 17'(s1_col_reg) * 17'(BYTES_PER_PIXEL);
    assign addr      = ADDR_BITS'(row_bytes) + ADDR_BITS'(col_bytes);

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_col_reg    <= col[13:0];
            s1_row_reg    <= row[13:0];
            s1_vis_reg    <= vis;
            s1_last_reg   <= pix_last;
            s1_colour_reg <= pix_colour;
        end
        if (out_free && s1_valid_reg)
        begin
            out_reg.pixel_address <= s1_vis_reg ? addr : '0;
            out_reg.visible       <= s1_vis_reg;
            out_reg.red_out       <= s1_colour_reg[23:16];
            out_reg.green_out     <= s1_colour_reg[15:8];
            out_reg.blue_out      <= s1_colour_reg[7:0];
            out_reg.last_pixel    <= s1_last_reg;
        end
    end

endmodule

### hdl/line_rasterizer_pixel_writer.sv
// Top level of the line rasterizer pixel writer with its configuration registers.
//
// Items enter through a queue-style port: an item transfers when push is high
// and full is low. A start item loads a line and gives no result; each tick
// item gives one pixel of the line, the end point first and then the others
// from the start point on, and a tick while no line is active gives nothing.
// Results leave through a second queue-style port: the oldest pixel is on
// result while empty is low and transfers when pop is high. One item is
// accepted every cycle while full is low. A pixel passes from its tick through
// the pixel queue, the clip stage and the output register, which is fed by the
// row-stride multiplier, in that order.
// When the receiver stalls, the output register, the clip stage and the
// four-entry pixel queue fill in turn, and full rises once the queue is full.
// Reset clears all queues, ends any line in progress and loads the registers
// with 640 by 480 pixels and a stride of 1920 bytes. The user must write the
// registers over the APB port only while the block is idle; the block does not
// enforce this. Width, height and stride lie at byte addresses 0, 4 and 8.
module line_rasterizer_pixel_writer
    import lrpw_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  lrpw_in_t    item,
    output logic        empty,
    input  logic        pop,
    output lrpw_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QW = 2 * COORD_BITS + 25;

    lrpw_cfg_t       cfg_reg;
    logic            take;
    logic            q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]   q_wr_data, q_rd_data;

    assign pready = 1'b1;
    assign full   = q_full;
    assign take   = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= IMAGE_WIDTH_RESET;
            cfg_reg.image_height  <= IMAGE_HEIGHT_RESET;
            cfg_reg.bytes_per_row <= BYTES_PER_ROW_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[13:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[13:0];
                REG_BYTES_PER_ROW: cfg_reg.bytes_per_row <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = 32'(cfg_reg.image_height);
            REG_BYTES_PER_ROW: prdata = 32'(cfg_reg.bytes_per_row);
            default:           prdata = '0;
        endcase
    end

    lrpw_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    lrpw_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    lrpw_back #(
        .COORD_BITS     (COORD_BITS),
        .BYTES_PER_PIXEL(BYTES_PER_PIXEL)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
